/* rtl/chgi_pkg.sv */
// Package for the chained hash group index: types, codes and sizes.
package chgi_pkg;

  localparam int POOL_ENTRIES_DEF = 1024;
  localparam int BUCKET_COUNT_DEF = 16384;

  // Command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FLAG_UPD  = 3'd3;
  localparam logic [2:0] ST_READ_ONLY = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] low_mark;
    logic [31:0] high_mark;
    logic [7:0]  group_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] found_low;
    logic [31:0] found_high;
    logic [7:0]  found_flag;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_HEAD_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_ALLOC,
    S_ALLOC_WAIT,
    S_UNLINK,
    S_RELINK
  } state_t;

endpackage

/* rtl/chgi_ram.sv */
// Generic single-port synchronous RAM with registered read.
module chgi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/chained_hash_group_index_core.sv */
// Top level of the chained hash group index: sequencer over bucket and entry memories.
// An unused command or a read-only write answers from the head state; any other
// request reads its bucket head and walks the chain one entry at a time; a new insert
// then allocates a free slot, a delete unlinks at the bucket head or patches the predecessor.
// One request at a time; the next is taken once the held result has been accepted.
// Reset: a clearing pass over all BUCKET_COUNT bucket heads empties them, no request taken.
module chained_hash_group_index_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  chgi_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output chgi_pkg::rsp_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import chgi_pkg::*;

  localparam int POOL_ENTRIES = POOL_ENTRIES_DEF;
  localparam int BUCKET_COUNT = BUCKET_COUNT_DEF;
  localparam int PW = $clog2(POOL_ENTRIES);      // slot index width
  localparam int LW = $clog2(POOL_ENTRIES + 1);  // link width, NIL = POOL_ENTRIES
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
  // entry word: live, next, key_hi, key_lo, low, high, flag
  localparam int EW = 1 + LW + 64 + 64 + 32 + 32 + 8;

  typedef struct packed {
    logic          live;
    logic [LW-1:0] nxt;
    logic [63:0]   khi;
    logic [63:0]   klo;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [7:0]    flag;
  } entry_t;

  state_t state, state_next;
  req_t   req;
  logic   write_enable;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] at, at_next, prev, prev_next;
  logic [LW:0]   steps, steps_next;
  logic [BW:0]   clr_cnt;
  logic [LW-1:0] del_nxt, del_nxt_next;   // successor of the entry being deleted
  logic [LW:0]   init_cnt, init_cnt_next; // slots below this were ever written
  logic [PW-1:0] e_raddr;                 // address of the read now on e_rdata
  rsp_t          rsp_next;
  logic          out_load;

  // bucket memory
  logic          b_we;
  logic [BW-1:0] b_addr;
  logic [LW-1:0] b_wdata, b_rdata;
  // entry memory
  logic          e_we;
  logic [PW-1:0] e_addr;
  entry_t        e_wdata, e_rdata;

  logic [BW-1:0] bucket;
  entry_t        e_view;
  logic          match;

  chgi_ram #(.WIDTH(LW), .DEPTH(BUCKET_COUNT)) u_bucket (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );
  chgi_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );

  // bucket count is a power of two: low key bits pick the bucket
  assign bucket = req.key_lo[BW-1:0];

  // entry read as seen through the fill count: fresh slots link to i+1
  always_comb begin
    e_view = e_rdata;
    if ((LW+1)'(e_raddr) >= init_cnt) begin
      e_view.live = 1'b0;
      e_view.nxt  = LW'(e_raddr) + LW'(1);
    end
  end
  assign match = e_view.live && e_view.khi == req.key_hi && e_view.klo == req.key_lo;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall  = (state != S_IDLE) || out_valid;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      write_enable <= 1'b1;
      free_head    <= '0;
      init_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      init_cnt  <= init_cnt_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + (BW+1)'(1);
      if (cfg_valid && cfg_ready) write_enable <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) req <= in_data;
    at      <= at_next;
    prev    <= prev_next;
    steps   <= steps_next;
    del_nxt <= del_nxt_next;
    e_raddr <= e_addr;
    if (out_load) out_data <= rsp_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    init_cnt_next  = init_cnt;
    at_next        = at;
    prev_next      = prev;
    steps_next     = steps;
    del_nxt_next   = del_nxt;
    out_load       = 1'b0;
    rsp_next       = '0;
    rsp_next.status = ST_NOT_FOUND;
    b_we    = 1'b0;
    b_addr  = bucket;
    b_wdata = NIL;
    e_we    = 1'b0;
    e_addr  = at[PW-1:0];
    e_wdata = e_view;
    unique case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_addr  = clr_cnt[BW-1:0];
        if (clr_cnt == (BW+1)'(BUCKET_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        // bucket head read goes out; unused code or read-only write answers at once
        prev_next  = NIL;
        steps_next = '0;
        if (req.cmd == CMD_UNUSED) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end else if (req.cmd != CMD_LOOKUP && !write_enable) begin
          rsp_next.status = ST_READ_ONLY;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HEAD_WAIT;
        end
      end
      S_HEAD_WAIT: begin
        at_next    = b_rdata;
        state_next = S_WALK;
      end
      S_WALK: begin
        // issue the read of entry at, or finish the walk
        if (at >= NIL || steps >= (LW+1)'(POOL_ENTRIES)) begin
          if (req.cmd == CMD_INSERT && free_head < NIL) begin
            at_next    = free_head;
            state_next = S_ALLOC;
          end else begin
            if (req.cmd == CMD_INSERT) rsp_next.status = ST_FULL;
            out_load   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (match) begin
          if (req.cmd == CMD_LOOKUP) begin
            rsp_next.status     = ST_OK;
            rsp_next.slot       = at[PW-1:0];
            rsp_next.found_low  = e_view.lo;
            rsp_next.found_high = e_view.hi;
            rsp_next.found_flag = e_view.flag;
            out_load   = 1'b1;
            state_next = S_IDLE;
          end else if (req.cmd == CMD_INSERT) begin
            // present key: rewrite the flag only
            e_we = 1'b1;
            e_wdata.flag    = req.group_flag;
            rsp_next.status = ST_FLAG_UPD;
            rsp_next.slot   = at[PW-1:0];
            out_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            // delete: free the slot, keep its successor for the splice
            e_we = 1'b1;
            e_wdata.live   = 1'b0;
            e_wdata.nxt    = free_head;
            free_head_next = at;
            del_nxt_next   = e_view.nxt;
            state_next     = S_UNLINK;
          end
        end else begin
          prev_next  = at;
          at_next    = e_view.nxt;
          steps_next = steps + (LW+1)'(1);
          state_next = S_WALK;
        end
      end
      S_ALLOC: begin
        // read the free slot to learn its successor, and the bucket head
        state_next = S_ALLOC_WAIT;
      end
      S_ALLOC_WAIT: begin
        free_head_next = e_view.nxt;
        if ((LW+1)'(at) >= init_cnt) init_cnt_next = (LW+1)'(at) + (LW+1)'(1);
        e_we = 1'b1;
        e_wdata.live = 1'b1;
        e_wdata.nxt  = b_rdata;
        e_wdata.khi  = req.key_hi;
        e_wdata.klo  = req.key_lo;
        e_wdata.lo   = req.low_mark;
        e_wdata.hi   = req.high_mark;
        e_wdata.flag = req.group_flag;
        b_we    = 1'b1;
        b_wdata = at;
        rsp_next.status = ST_OK;
        rsp_next.slot   = at[PW-1:0];
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      S_UNLINK: begin
        // bucket head takes the successor, or read the predecessor to patch it
        if (prev >= NIL) begin
          b_we    = 1'b1;
          b_wdata = del_nxt;
          rsp_next.status = ST_OK;
          rsp_next.slot   = at[PW-1:0];
          out_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          e_addr     = prev[PW-1:0];
          state_next = S_RELINK;
        end
      end
      S_RELINK: begin
        e_addr = prev[PW-1:0];
        e_we   = 1'b1;
        e_wdata.nxt = del_nxt;
        rsp_next.status = ST_OK;
        rsp_next.slot   = at[PW-1:0];
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // no request is taken while a result is held
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("request taken while result pending");
  // free head is a pool index or empty
  assert property (@(posedge clk) disable iff (rst) free_head <= NIL)
    else $error("free head out of range");
  // configuration is only taken when idle
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (state == S_IDLE))
    else $error("config write while busy");
  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

/* tb/chgi_checker.sv */
// Checker for the chained hash group index: watches the channels, predicts and compares.
module chgi_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  chgi_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  chgi_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_data,
  output int             fail_count,
  output int             pending
);
  import chgi_pkg::*;

  localparam int POOL = POOL_ENTRIES_DEF;
  localparam int BUCKETS = BUCKET_COUNT_DEF;
  localparam logic [10:0] EMPTY = 11'(POOL);

  // Shadow copy of the index
  logic [10:0] head_of_bucket [BUCKETS];
  logic [10:0] free_top;
  logic [10:0] link [POOL];
  bit          live [POOL];
  logic [63:0] stored_hi [POOL];
  logic [63:0] stored_lo [POOL];
  logic [31:0] stored_low [POOL];
  logic [31:0] stored_high [POOL];
  logic [7:0]  stored_flag [POOL];
  bit          writable;

  rsp_t expected_rsp [$];

  function automatic int bucket_index(logic [63:0] klo);
    return int'(klo[31:0] % BUCKETS);
  endfunction

  // Chain walk: matching slot or EMPTY, with predecessor
  function automatic logic [10:0] locate(logic [63:0] khi, logic [63:0] klo,
                                         output logic [10:0] pred);
    logic [10:0] at;
    logic [10:0] behind;
    at = head_of_bucket[bucket_index(klo)];
    behind = EMPTY;
    pred = EMPTY;
    for (int n = 0; n < POOL; n++) begin
      if (at >= EMPTY) break;
      if (live[at] && stored_hi[at] == khi && stored_lo[at] == klo) begin
        pred = behind;
        return at;
      end
      behind = at;
      at = link[at];
    end
    return EMPTY;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    logic [10:0] at;
    logic [10:0] pred;
    int b;
    o = '0;
    o.status = ST_NOT_FOUND;
    b = bucket_index(r.key_lo);
    case (r.cmd)
      CMD_LOOKUP: begin
        at = locate(r.key_hi, r.key_lo, pred);
        if (at < EMPTY) begin
          o.status = ST_OK;
          o.slot = at[9:0];
          o.found_low = stored_low[at];
          o.found_high = stored_high[at];
          o.found_flag = stored_flag[at];
        end
      end
      CMD_INSERT: begin
        if (!writable) o.status = ST_READ_ONLY;
        else begin
          at = locate(r.key_hi, r.key_lo, pred);
          if (at < EMPTY) begin
            stored_flag[at] = r.group_flag;
            o.status = ST_FLAG_UPD;
            o.slot = at[9:0];
          end else if (free_top >= EMPTY) begin
            o.status = ST_FULL;
          end else begin
            at = free_top;
            free_top = link[at];
            stored_hi[at] = r.key_hi;
            stored_lo[at] = r.key_lo;
            stored_low[at] = r.low_mark;
            stored_high[at] = r.high_mark;
            stored_flag[at] = r.group_flag;
            live[at] = 1'b1;
            link[at] = head_of_bucket[b];
            head_of_bucket[b] = at;
            o.status = ST_OK;
            o.slot = at[9:0];
          end
        end
      end
      CMD_DELETE: begin
        if (!writable) o.status = ST_READ_ONLY;
        else begin
          at = locate(r.key_hi, r.key_lo, pred);
          if (at < EMPTY) begin
            if (pred < EMPTY) link[pred] = link[at];
            else head_of_bucket[b] = link[at];
            live[at] = 1'b0;
            link[at] = free_top;
            free_top = at;
            o.status = ST_OK;
            o.slot = at[9:0];
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) head_of_bucket[i] = EMPTY;
      for (int i = 0; i < POOL; i++) begin
        link[i] = 11'(i + 1);
        live[i] = 1'b0;
      end
      free_top = '0;
      writable = 1'b1;
      expected_rsp.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) writable = cfg_data;
      if (in_valid && !in_stall) expected_rsp.push_back(apply_request(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response with none expected: %p", out_data);
          errs = errs + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.status !== out_data.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errs = errs + 1;
          end
          if (want.slot !== out_data.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
            errs = errs + 1;
          end
          if (want.found_low !== out_data.found_low) begin
            $error("found_low: expected %h, got %h", want.found_low, out_data.found_low);
            errs = errs + 1;
          end
          if (want.found_high !== out_data.found_high) begin
            $error("found_high: expected %h, got %h", want.found_high,
                   out_data.found_high);
            errs = errs + 1;
          end
          if (want.found_flag !== out_data.found_flag) begin
            $error("found_flag: expected %h, got %h", want.found_flag,
                   out_data.found_flag);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* tb/tb_chained_hash_group_index_core.sv */
// Testbench top for the chained hash group index: stimulus, stalls and verdict.
module tb_chained_hash_group_index_core;
  import chgi_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   long_hold = 1'b0;

  // Small key pool so inserts, repeats and deletes collide often
  logic [63:0] key_hi_pool [16];
  logic [63:0] key_lo_pool [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_group_index_core u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  chgi_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      out_stall <= (gap != 0);
      repeat (gap) @(negedge clk);
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  task automatic send_request(req_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_enable_reg(logic v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t make_request(logic [1:0] c, int k);
    req_t r;
    r.cmd = c;
    r.key_hi = key_hi_pool[k];
    r.key_lo = key_lo_pool[k];
    r.low_mark = $urandom();
    r.high_mark = $urandom();
    r.group_flag = 8'($urandom());
    return r;
  endfunction

  initial begin
    req_t r;
    int k;
    for (int i = 0; i < 16; i++) begin
      key_hi_pool[i] = {$urandom(), $urandom()};
      key_lo_pool[i] = {$urandom(), $urandom()};
    end
    // several keys share one bucket to build chains
    for (int i = 0; i < 6; i++) key_lo_pool[i][13:0] = 14'h1234;
    key_hi_pool[15] = '1;
    key_lo_pool[15] = '1;
    key_hi_pool[14] = '0;
    key_lo_pool[14] = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: insert, repeat insert, lookups, unused command, deletes
    r = make_request(CMD_LOOKUP, 15); send_request(r);
    r = make_request(CMD_INSERT, 15);
    r.low_mark = '1; r.high_mark = '1; r.group_flag = '1;
    send_request(r);
    r = make_request(CMD_INSERT, 14);
    r.low_mark = '0; r.high_mark = '0; r.group_flag = '0;
    send_request(r);
    for (int i = 0; i < 6; i++) begin
      r = make_request(CMD_INSERT, i); send_request(r);
    end
    r = make_request(CMD_INSERT, 2); send_request(r);
    r = make_request(CMD_LOOKUP, 15); send_request(r);
    r = make_request(CMD_LOOKUP, 3); send_request(r);
    r = make_request(CMD_UNUSED, 3); send_request(r);
    r = make_request(CMD_DELETE, 3); send_request(r);
    r = make_request(CMD_DELETE, 3); send_request(r);
    r = make_request(CMD_DELETE, 5); send_request(r);
    r = make_request(CMD_DELETE, 0); send_request(r);
    r = make_request(CMD_LOOKUP, 1); send_request(r);

    // Read-only phase
    write_enable_reg(1'b0);
    r = make_request(CMD_INSERT, 7); send_request(r);
    r = make_request(CMD_DELETE, 1); send_request(r);
    r = make_request(CMD_LOOKUP, 1); send_request(r);
    write_enable_reg(1'b1);

    // Mixed phase: fresh keys over a few buckets fill the pool, with requests
    // on the small key set in between; hold the receiver off once mid-run
    for (int n = 0; n < 1060; n++) begin
      if (n == 300) long_hold = 1'b1;
      k = $urandom_range(0, 15);
      if (n % 40 == 39) begin
        case ($urandom_range(0, 3))
          0:       r = make_request(CMD_INSERT, k);
          1:       r = make_request(CMD_LOOKUP, k);
          2:       r = make_request(CMD_DELETE, k);
          default: r = make_request(CMD_UNUSED, k);
        endcase
      end else begin
        r = make_request(CMD_INSERT, k);
        r.key_hi = {$urandom(), $urandom()};
        r.key_lo = {$urandom(), $urandom()};
        r.key_lo[13:0] = {9'h091, 5'($urandom())};
      end
      send_request(r);
    end

    // Probe the full pool, free one and reuse it
    r = make_request(CMD_INSERT, 9); send_request(r);
    r = make_request(CMD_DELETE, 15); send_request(r);
    r = make_request(CMD_INSERT, 9); send_request(r);
    r = make_request(CMD_LOOKUP, 9); send_request(r);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
